/* rtl/pbba_pkg.sv */
// Package: shared types and constants of the partitioned bump block allocator.
`timescale 1ns / 1ps
`default_nettype none
package pbba_pkg;

    localparam int unsigned CUR_W   = 25;
    localparam int unsigned BLK_W   = 21;
    localparam int unsigned HDR_W   = 16;
    localparam int unsigned CNT_W   = 32;
    localparam int unsigned OFF_W   = 48;
    localparam int unsigned HOST_W  = 4;
    localparam int unsigned OWN_W   = 3;
    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned Q_DEPTH = 2;

    localparam logic [2:0] REG_POOL_EN  = 3'd0;
    localparam logic [2:0] REG_OWN_HOST = 3'd1;
    localparam logic [2:0] REG_HOST_CNT = 3'd2;
    localparam logic [2:0] REG_BLK_SIZE = 3'd3;
    localparam logic [2:0] REG_SEG_BLKS = 3'd4;
    localparam logic [2:0] REG_PRIV_CNT = 3'd5;
    localparam logic [2:0] REG_PEER_RES = 3'd6;
    localparam logic [2:0] REG_HDR_SIZE = 3'd7;

    localparam logic ACT_LOCAL = 1'b0;
    localparam logic ACT_PEER  = 1'b1;

    typedef struct packed {
        logic              action;
        logic [HOST_W-1:0] owner_id;
    } t_cmd;

    typedef struct packed {
        logic [OFF_W-1:0] block_offset;
        logic             failed;
        logic [CNT_W-1:0] exhaust_count;
    } t_result;

    typedef struct packed {
        logic              pool_enabled;
        logic [OWN_W-1:0]  own_host;
        logic [HOST_W-1:0] host_count;
        logic [BLK_W-1:0]  block_bytes;
        logic [CUR_W-1:0]  blocks_per_segment;
        logic [CUR_W-1:0]  private_block_count;
        logic [CUR_W-1:0]  reserved_per_peer;
        logic [HDR_W-1:0]  header_bytes;
    } t_cfg;

    // Classified request handed from front to back end
    typedef struct packed {
        logic              ok;
        logic              peer;
        logic [HOST_W-1:0] host;
        logic [OWN_W-1:0]  rank;
        logic [CUR_W-1:0]  idx;
        logic [CNT_W-1:0]  count;
    } t_job;

endpackage
`default_nettype wire

/* rtl/pbba_cfg_regs.sv */
// Configuration register bank behind the APB-style port.
`timescale 1ns / 1ps
`default_nettype none
module pbba_cfg_regs
    import pbba_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg       r_cfg;
    logic [2:0] w_idx;
    logic       w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[ADDR_W-1:2];
    assign w_wr   = psel & penable & pwrite & pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pool_enabled        <= 1'b0;
            r_cfg.own_host            <= '0;
            r_cfg.host_count          <= HOST_W'(1);
            r_cfg.block_bytes         <= BLK_W'(64);
            r_cfg.blocks_per_segment  <= CUR_W'(1);
            r_cfg.private_block_count <= '0;
            r_cfg.reserved_per_peer   <= '0;
            r_cfg.header_bytes        <= HDR_W'(64);
        end else if (w_wr) begin
            unique case (w_idx)
                REG_POOL_EN:  r_cfg.pool_enabled        <= pwdata[0];
                REG_OWN_HOST: r_cfg.own_host            <= pwdata[OWN_W-1:0];
                REG_HOST_CNT: r_cfg.host_count          <= pwdata[HOST_W-1:0];
                REG_BLK_SIZE: r_cfg.block_bytes         <= pwdata[BLK_W-1:0];
                REG_SEG_BLKS: r_cfg.blocks_per_segment  <= pwdata[CUR_W-1:0];
                REG_PRIV_CNT: r_cfg.private_block_count <= pwdata[CUR_W-1:0];
                REG_PEER_RES: r_cfg.reserved_per_peer   <= pwdata[CUR_W-1:0];
                REG_HDR_SIZE: r_cfg.header_bytes        <= pwdata[HDR_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_POOL_EN:  prdata = DATA_W'(r_cfg.pool_enabled);
            REG_OWN_HOST: prdata = DATA_W'(r_cfg.own_host);
            REG_HOST_CNT: prdata = DATA_W'(r_cfg.host_count);
            REG_BLK_SIZE: prdata = DATA_W'(r_cfg.block_bytes);
            REG_SEG_BLKS: prdata = DATA_W'(r_cfg.blocks_per_segment);
            REG_PRIV_CNT: prdata = DATA_W'(r_cfg.private_block_count);
            REG_PEER_RES: prdata = DATA_W'(r_cfg.reserved_per_peer);
            REG_HDR_SIZE: prdata = DATA_W'(r_cfg.header_bytes);
        endcase
    end

endmodule
`default_nettype wire

/* rtl/pbba_front.sv */
// Front end: classifies requests, bumps cursors and keeps exhaustion counters.
`timescale 1ns / 1ps
`default_nettype none
module pbba_front
    import pbba_pkg::*;
#(
    parameter int unsigned MAX_HOSTS = 8
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_accept,
    input  wire t_cmd i_cmd,
    input  wire t_cfg i_cfg,
    output t_job      o_job
);

    localparam int unsigned IW = (MAX_HOSTS > 1) ? $clog2(MAX_HOSTS) : 1;

    logic [CUR_W-1:0] r_local,  n_local;
    logic [CUR_W-1:0] r_pc [MAX_HOSTS];
    logic [CUR_W-1:0] n_pc [MAX_HOSTS];
    logic [CNT_W-1:0] r_pe [MAX_HOSTS];
    logic [CNT_W-1:0] n_pe [MAX_HOSTS];

    logic          w_in_range;
    logic [IW-1:0] w_sel;
    logic          w_peer_ok;

    assign w_in_range = (5'(i_cmd.owner_id) < 5'(MAX_HOSTS));
    assign w_sel      = i_cmd.owner_id[IW-1:0];
    assign w_peer_ok  = i_cfg.pool_enabled && w_in_range
                        && (i_cmd.owner_id < i_cfg.host_count)
                        && (i_cmd.owner_id != {1'b0, i_cfg.own_host})
                        && (i_cfg.reserved_per_peer != '0);

    always_comb begin
        n_local = r_local;
        n_pc    = r_pc;
        n_pe    = r_pe;
        o_job.ok    = 1'b0;
        o_job.peer  = i_cmd.action;
        o_job.host  = {1'b0, i_cfg.own_host};
        o_job.rank  = '0;
        o_job.idx   = '0;
        o_job.count = '0;
        if (i_cmd.action == ACT_LOCAL) begin
            if (i_cfg.pool_enabled) begin
                if (r_local >= i_cfg.private_block_count) begin
                    n_local = i_cfg.private_block_count;
                end else begin
                    n_local   = r_local + CUR_W'(1);
                    o_job.ok  = 1'b1;
                    o_job.idx = r_local;
                end
            end
        end else if (w_in_range) begin
            o_job.host = i_cmd.owner_id;
            o_job.rank = ({1'b0, i_cfg.own_host} > i_cmd.owner_id)
                         ? i_cfg.own_host - OWN_W'(1) : i_cfg.own_host;
            if (w_peer_ok) begin
                if (r_pc[w_sel] >= i_cfg.reserved_per_peer) begin
                    n_pc[w_sel] = i_cfg.reserved_per_peer;
                    n_pe[w_sel] = r_pe[w_sel] + CNT_W'(1);
                end else begin
                    n_pc[w_sel] = r_pc[w_sel] + CUR_W'(1);
                    o_job.ok    = 1'b1;
                    o_job.idx   = r_pc[w_sel];
                end
            end
            o_job.count = n_pe[w_sel];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local <= '0;
            for (int i = 0; i < MAX_HOSTS; i++) begin
                r_pc[i] <= '0;
                r_pe[i] <= '0;
            end
        end else if (i_accept) begin
            r_local <= n_local;
            r_pc    <= n_pc;
            r_pe    <= n_pe;
        end
    end

endmodule
`default_nettype wire

/* rtl/pbba_queue.sv */
// Short job queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module pbba_queue
    import pbba_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_valid,
    output t_job      o_job
);

    localparam int unsigned PW = $clog2(Q_DEPTH);

    t_job                r_mem [Q_DEPTH];
    logic [PW-1:0]       r_wp;
    logic [PW-1:0]       r_rp;
    logic [$clog2(Q_DEPTH+1)-1:0] r_cnt;
    logic                w_pop;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == ($clog2(Q_DEPTH+1))'(Q_DEPTH));
    assign w_pop   = i_pop & o_valid;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(Q_DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (w_pop) begin
                r_rp <= (r_rp == PW'(Q_DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (i_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && w_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/pbba_back.sv */
// Back end: offset pipeline (stage 1, stage 2) and result register.
`timescale 1ns / 1ps
`default_nettype none
module pbba_back
    import pbba_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_job i_job,
    input  wire t_cfg i_cfg,
    output logic      o_done,
    output t_result   o_result
);

    localparam int unsigned PR_W = BLK_W + CUR_W;
    localparam int unsigned RR_W = OWN_W + CUR_W;

    // stage 1
    logic              r_v1;
    t_job              r_j1;
    logic [PR_W-1:0]   r_bs;
    logic [PR_W-1:0]   r_is;
    logic [PR_W-1:0]   r_ps;
    logic [RR_W-1:0]   r_rr;
    // stage 2
    logic              r_v2;
    t_job              r_j2;
    logic [OFF_W-1:0]  r_seg;
    logic [OFF_W-1:0]  r_rs;
    logic [OFF_W-1:0]  r_lin;
    // result
    logic              r_done;
    t_result           r_res;

    always_ff @(posedge i_clk) begin
        r_j1 <= i_job;
        r_bs <= PR_W'(i_cfg.blocks_per_segment) * PR_W'(i_cfg.block_bytes);
        r_is <= PR_W'(i_job.idx) * PR_W'(i_cfg.block_bytes);
        r_ps <= i_job.peer ? PR_W'(i_cfg.private_block_count) * PR_W'(i_cfg.block_bytes)
                           : '0;
        r_rr <= i_job.peer ? RR_W'(i_job.rank) * RR_W'(i_cfg.reserved_per_peer) : '0;

        r_j2  <= r_j1;
        r_seg <= OFF_W'(r_j1.host) * OFF_W'(r_bs);
        r_rs  <= OFF_W'(r_rr) * OFF_W'(i_cfg.block_bytes);
        r_lin <= OFF_W'(i_cfg.header_bytes) + OFF_W'(r_is) + OFF_W'(r_ps);

        r_res.block_offset  <= r_j2.ok ? r_seg + r_rs + r_lin : '0;
        r_res.failed        <= ~r_j2.ok;
        r_res.exhaust_count <= r_j2.count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_valid;
            r_v2   <= r_v1;
            r_done <= r_v2;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule
`default_nettype wire

/* rtl/partitioned_bump_block_allocator_core.sv */
// Top level of the partitioned bump block allocator.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+----------------------------------
//  command  | start / busy            | i_cmd    (action, owner_id)
//  result   | o_done (one-cycle beat) | o_result (offset, failed, count)
//  config   | psel/penable/pwrite     | paddr, pwdata, prdata
//
// One beat a cycle is taken while busy is low; the front end updates cursors in the accept cycle.
// A result passes the queue, two multiply stages and the final add into the
// result register before it leaves.
// Reset is synchronous, active low; cursors and counters clear at the clock edge.
// The result side cannot stall, so busy is raised only when the queue is full.
`timescale 1ns / 1ps
`default_nettype none
module partitioned_bump_block_allocator_core
    import pbba_pkg::*;
#(
    parameter int unsigned MAX_HOSTS = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire t_cmd              i_cmd,
    output logic                   o_done,
    output t_result                o_result,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    t_cfg w_cfg;
    t_job w_job_in;
    t_job w_job_out;
    logic w_full;
    logic w_qvalid;
    logic w_accept;

    assign busy     = w_full;
    assign w_accept = start & ~busy;

    pbba_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    pbba_front #(
        .MAX_HOSTS (MAX_HOSTS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_cmd    (i_cmd),
        .i_cfg    (w_cfg),
        .o_job    (w_job_in)
    );

    pbba_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_job   (w_job_in),
        .i_pop   (1'b1),
        .o_full  (w_full),
        .o_valid (w_qvalid),
        .o_job   (w_job_out)
    );

    pbba_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_qvalid),
        .i_job    (w_job_out),
        .i_cfg    (w_cfg),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule
`default_nettype wire

/* test/testbench.sv */
// Testbench: partitioned bump allocator checked against a cycle-free allocation predictor.
`timescale 1ns / 1ps
module testbench;
    import pbba_pkg::*;

    localparam int HOSTS = 8;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_cmd                 i_cmd;
    logic                 o_done;
    t_result              o_result;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [DATA_W-1:0]    pwdata;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    partitioned_bump_block_allocator_core #(.MAX_HOSTS(HOSTS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_cmd(i_cmd),
        .o_done(o_done), .o_result(o_result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    t_cfg             pool_cfg;
    logic [CUR_W-1:0] own_cursor;
    logic [CUR_W-1:0] owner_cursor [HOSTS];
    logic [CNT_W-1:0] owner_misses [HOSTS];
    t_result          pending_blocks [$];
    int unsigned      errors;
    bit               gaps_on;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [63:0] segment_start(logic [3:0] host);
        return 64'(pool_cfg.header_bytes) +
               64'(host) * 64'(pool_cfg.blocks_per_segment) * 64'(pool_cfg.block_bytes);
    endfunction

    function automatic t_result allocate_block(t_cmd c);
        t_result          r;
        logic [63:0]      off;
        logic [2:0]       rank;
        logic [2:0]       o;
        logic [CUR_W-1:0] idx;
        r        = '0;
        r.failed = 1'b1;
        off      = '0;
        o        = c.owner_id[2:0];
        if (c.action == ACT_LOCAL) begin
            if (pool_cfg.pool_enabled) begin
                if (own_cursor >= pool_cfg.private_block_count) begin
                    own_cursor = pool_cfg.private_block_count;
                end else begin
                    off = segment_start({1'b0, pool_cfg.own_host}) +
                          64'(own_cursor) * 64'(pool_cfg.block_bytes);
                    own_cursor = own_cursor + 1'b1;
                    r.failed = 1'b0;
                end
            end
        end else if (c.owner_id < HOSTS) begin
            if (pool_cfg.pool_enabled && c.owner_id < pool_cfg.host_count &&
                    o != pool_cfg.own_host && pool_cfg.reserved_per_peer != 0) begin
                if (owner_cursor[o] >= pool_cfg.reserved_per_peer) begin
                    owner_cursor[o] = pool_cfg.reserved_per_peer;
                    owner_misses[o] = owner_misses[o] + 1'b1;
                end else begin
                    idx  = owner_cursor[o];
                    rank = (pool_cfg.own_host > o) ? pool_cfg.own_host - 1'b1 : pool_cfg.own_host;
                    off  = segment_start(c.owner_id) +
                           64'(pool_cfg.private_block_count) * 64'(pool_cfg.block_bytes) +
                           64'(rank) * 64'(pool_cfg.reserved_per_peer) *
                               64'(pool_cfg.block_bytes) +
                           64'(idx) * 64'(pool_cfg.block_bytes);
                    owner_cursor[o] = idx + 1'b1;
                    r.failed = 1'b0;
                end
            end
            r.exhaust_count = owner_misses[o];
        end
        r.block_offset = off[OFF_W-1:0];
        return r;
    endfunction

    // accept and compare at the rising edge; DUT outputs still hold pre-edge values
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (o_done) begin
                if (pending_blocks.size() == 0) begin
                    errors++;
                    if (errors <= 200)
                        $display("%0t: result beat with none expected: %h", $time, o_result);
                end else begin
                    want = pending_blocks.pop_front();
                    if (o_result.block_offset !== want.block_offset ||
                            o_result.failed !== want.failed ||
                            o_result.exhaust_count !== want.exhaust_count) begin
                        errors++;
                        if (errors <= 200)
                            $display("%0t: expected offset %h failed %b count %0d", $time,
                                     want.block_offset, want.failed, want.exhaust_count,
                                     ", got offset %h failed %b count %0d",
                                     o_result.block_offset, o_result.failed,
                                     o_result.exhaust_count);
                    end
                end
            end
            if (start && !busy)
                pending_blocks.push_back(allocate_block(i_cmd));
        end
    end

    task automatic send_cmd(logic action, logic [3:0] owner);
        while (gaps_on && $urandom_range(0, 99) < 19) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start          = 1'b1;
        i_cmd.action   = action;
        i_cmd.owner_id = owner;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_blocks.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_POOL_EN:  pool_cfg.pool_enabled        = value[0];
            REG_OWN_HOST: pool_cfg.own_host            = value[OWN_W-1:0];
            REG_HOST_CNT: pool_cfg.host_count          = value[HOST_W-1:0];
            REG_BLK_SIZE: pool_cfg.block_bytes         = value[BLK_W-1:0];
            REG_SEG_BLKS: pool_cfg.blocks_per_segment  = value[CUR_W-1:0];
            REG_PRIV_CNT: pool_cfg.private_block_count = value[CUR_W-1:0];
            REG_PEER_RES: pool_cfg.reserved_per_peer   = value[CUR_W-1:0];
            REG_HDR_SIZE: pool_cfg.header_bytes        = value[HDR_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_pool(logic en, logic [2:0] own, logic [3:0] hosts, logic [31:0] blk,
                            logic [31:0] seg, logic [31:0] priv, logic [31:0] res,
                            logic [31:0] hdr);
        wait_idle();
        write_reg(REG_POOL_EN,  {31'd0, en});
        write_reg(REG_OWN_HOST, {29'd0, own});
        write_reg(REG_HOST_CNT, {28'd0, hosts});
        write_reg(REG_BLK_SIZE, blk);
        write_reg(REG_SEG_BLKS, seg);
        write_reg(REG_PRIV_CNT, priv);
        write_reg(REG_PEER_RES, res);
        write_reg(REG_HDR_SIZE, hdr);
    endtask

    function automatic logic [31:0] pick_size(int unsigned typical);
        case ($urandom_range(0, 7))
            0: begin
                return 32'd0;
            end
            1: begin
                return $urandom;
            end
            2: begin
                return $urandom_range(typical, typical * 64);
            end
            default: begin
                return $urandom_range(0, typical);
            end
        endcase
    endfunction

    task automatic randomise_pool();
        logic [31:0] blk;
        logic [3:0]  hosts;
        case ($urandom_range(0, 5))
            0: begin
                blk = 32'd1;
            end
            1: begin
                blk = 32'd1048576;
            end
            2: begin
                blk = $urandom;
            end
            default: begin
                blk = $urandom_range(1, 4096);
            end
        endcase
        hosts = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(2, 8));
        set_pool($urandom_range(0, 9) != 0, 3'($urandom_range(0, 7)), hosts, blk,
                 ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(1, 1000),
                 pick_size(12), pick_size(5), $urandom);
    endtask

    task automatic send_random(int unsigned count);
        int unsigned pick;
        logic [3:0]  owner;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 85 && pool_cfg.host_count != 0)
                owner = 4'($urandom_range(0, int'(pool_cfg.host_count) - 1));
            else
                owner = 4'($urandom_range(0, 15));
            send_cmd((pick < 40) ? ACT_LOCAL : ACT_PEER, owner);
        end
    endtask

    task automatic test_reset_state();
        send_cmd(ACT_LOCAL, 4'd0);
        send_cmd(ACT_PEER, 4'd0);
        send_cmd(ACT_PEER, 4'd15);
    endtask

    task automatic test_partitions();
        set_pool(1'b1, 3'd3, 4'd5, 32'd64, 32'd16, 32'd2, 32'd2, 32'd128);
        repeat (3) send_cmd(ACT_LOCAL, 4'd9);
        repeat (3) send_cmd(ACT_PEER, 4'd0);
        send_cmd(ACT_PEER, 4'd4);
        send_cmd(ACT_PEER, 4'd3);
        send_cmd(ACT_PEER, 4'd5);
        send_cmd(ACT_PEER, 4'd12);
        wait_idle();
        write_reg(REG_POOL_EN, 32'd0);
        send_cmd(ACT_LOCAL, 4'd0);
        send_cmd(ACT_PEER, 4'd0);
        wait_idle();
        write_reg(REG_POOL_EN, 32'd1);
        write_reg(REG_PEER_RES, 32'd0);
        send_cmd(ACT_PEER, 4'd1);
    endtask

    task automatic test_extremes();
        set_pool(1'b1, 3'd7, 4'd15, 32'h001F_FFFF, 32'h01FF_FFFF, 32'h01FF_FFFF,
                 32'h01FF_FFFF, 32'h0000_FFFF);
        send_cmd(ACT_LOCAL, 4'd0);
        send_cmd(ACT_PEER, 4'd6);
        send_cmd(ACT_PEER, 4'd0);
        send_cmd(ACT_PEER, 4'd9);
        send_cmd(ACT_PEER, 4'd15);
        set_pool(1'b1, 3'd6, 4'd0, 32'd1048576, 32'd16777216, 32'd16777216,
                 32'd16777216, 32'hFFFF_FFFF);
        send_cmd(ACT_PEER, 4'd1);
        send_cmd(ACT_LOCAL, 4'd15);
    endtask

    task automatic test_random_traffic(int unsigned phases);
        repeat (phases) begin
            randomise_pool();
            send_random($urandom_range(50, 70));
        end
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        set_pool(1'b1, 3'd2, 4'd8, 32'd256, 32'd400, 32'd60, 32'd40, 32'd64);
        send_random(100);
        gaps_on = 1'b1;
    endtask

    task automatic test_drain_pause();
        randomise_pool();
        write_reg(REG_POOL_EN, 32'd1);
        send_random(30);
        wait_idle();
        send_random(30);
    endtask

    initial begin
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_cmd   = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        errors  = 0;
        gaps_on = 1'b1;
        pool_cfg = '{pool_enabled: 1'b0, own_host: '0, host_count: 4'd1, block_bytes: 21'd64,
                     blocks_per_segment: 25'd1, private_block_count: '0,
                     reserved_per_peer: '0, header_bytes: 16'd64};
        own_cursor = '0;
        for (int i = 0; i < HOSTS; i++) begin
            owner_cursor[i] = '0;
            owner_misses[i] = '0;
        end
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_partitions();
        test_extremes();
        test_random_traffic(4);
        test_back_to_back();
        test_drain_pause();
        test_random_traffic(4);

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/pbba_pkg.sv
rtl/pbba_cfg_regs.sv
rtl/pbba_front.sv
rtl/pbba_queue.sv
rtl/pbba_back.sv
rtl/partitioned_bump_block_allocator_core.sv
test/testbench.sv
